[sv/dir_pkg.sv]
package dir_pkg;

	localparam int unsigned ExpW = 11;
	localparam int unsigned SigW = 53;
	localparam int unsigned StepW = 12;
	localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] ExpMask = 64'h7FF0_0000_0000_0000;

	typedef struct packed {
		logic load;
		logic norm;
		logic step;
		logic fix;
		logic pack;
	} dir_cmd_t;

	typedef struct packed {
		logic special;
		logic norm_done;
		logic steps_done;
		logic pack_done;
	} dir_stat_t;

endpackage

[sv/double_ieee_remainder.sv]
// Computes the IEEE 754 binary64 remainder x REM p, one transaction at a time.
// After the input transaction the block normalizes the dividend and then the divisor
// one bit per cycle, checking the operands for special cases as it goes, and then
// sets up the reduction. It then reduces the dividend modulo twice the divisor one
// quotient bit per cycle, corrects the remainder, and packs it, shifting it one bit
// per step to normalize it. Special operands, and dividends far below the divisor,
// skip the reduction and go straight from normalization to the output.
// A new input is taken only once the previous result has been delivered.
module double_ieee_remainder
	import dir_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [127:0] s_tdata, // divisor_bits [127:64], dividend_bits [63:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata  // remainder_bits
);

	dir_cmd_t  cmd;
	dir_stat_t stat;
	logic      busy;

	assign s_tready = !busy;

	dir_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
		.stat(stat), .cmd(cmd), .busy(busy), .res_valid(m_tvalid)
	);

	dir_dp u_dp (
		.clk(clk), .dividend_bits(s_tdata[63:0]), .divisor_bits(s_tdata[127:64]),
		.cmd(cmd), .stat(stat), .remainder_bits(m_tdata)
	);

endmodule

[sv/dir_ctrl.sv]
module dir_ctrl
	import dir_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  logic      out_fire,
	input  dir_stat_t stat,
	output dir_cmd_t  cmd,
	output logic      busy,
	output logic      res_valid
);

	typedef enum logic [2:0] {S_IDLE, S_NORM, S_STEP, S_FIX, S_PACK, S_OUT} state_t;
	state_t state_q;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.norm = (state_q == S_NORM);
		cmd.step = (state_q == S_STEP);
		cmd.fix = (state_q == S_FIX);
		cmd.pack = (state_q == S_PACK);
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_NORM;
				S_NORM: begin
					if (stat.special) begin
						state_q <= S_OUT;
						res_valid <= 1'b1;
					end else if (stat.norm_done) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: if (stat.steps_done) state_q <= S_FIX;
				S_FIX: state_q <= S_PACK;
				S_PACK: begin
					if (stat.pack_done) begin
						state_q <= S_OUT;
						res_valid <= 1'b1;
					end
				end
				S_OUT: begin
					if (out_fire) begin
						state_q <= S_IDLE;
						res_valid <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[sv/dir_dp.sv]
module dir_dp
	import dir_pkg::*;
(
	input  logic        clk,
	input  logic [63:0] dividend_bits,
	input  logic [63:0] divisor_bits,
	input  dir_cmd_t    cmd,
	output dir_stat_t   stat,
	output logic [63:0] remainder_bits
);

	logic        sx_q;
	logic [62:0] ax_q, ap_q;
	logic [SigW-1:0] mx_q, mp_q;
	logic [StepW-1:0] ex_q, ep_q;
	logic [SigW+1:0] acc_q;
	logic [SigW+1:0] pu_q;
	logic signed [SigW+2:0] r_q;
	logic [StepW-1:0] cnt_q;
	logic [StepW-1:0] base_q;
	logic        sign_q;
	logic [SigW+1:0] mag_q;
	logic [63:0] res_q;
	logic        special_q;
	logic        done_q;

	logic nx, np;
	assign nx = mx_q[SigW-1];
	assign np = mp_q[SigW-1];

	logic sp_nan, sp_pass;
	assign sp_nan = (ap_q == '0) || ({1'b0, ax_q} >= ExpMask) || ({1'b0, ap_q} > ExpMask);
	assign sp_pass = ({1'b0, ap_q} == ExpMask) || (ax_q == '0);

	logic [SigW+1:0] mod2, acc2;
	assign mod2 = {1'b0, mp_q, 1'b0};
	assign acc2 = {acc_q[SigW:0], 1'b0};

	logic signed [SigW+2:0] pu_s, r_m;
	assign pu_s = $signed({1'b0, pu_q});
	assign r_m = r_q - pu_s;

	// The exponent is below the subnormal range, so the significand must move right.
	logic base_low;
	assign base_low = base_q[StepW-1] || (base_q == '0);

	assign stat.special = special_q;
	assign stat.norm_done = done_q;
	assign stat.steps_done = (cnt_q == '0);
	assign stat.pack_done = (mag_q == '0) ||
		(mag_q[SigW+1:SigW] == 2'b00 && !base_low && (mag_q[SigW-1] || base_q == 12'd1));
	assign remainder_bits = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q <= dividend_bits[63];
			ax_q <= dividend_bits[62:0];
			ap_q <= divisor_bits[62:0];
			mx_q <= {(dividend_bits[62:52] != '0), dividend_bits[51:0]};
			mp_q <= {(divisor_bits[62:52] != '0), divisor_bits[51:0]};
			ex_q <= (dividend_bits[62:52] == '0) ? 12'd1 : {1'b0, dividend_bits[62:52]};
			ep_q <= (divisor_bits[62:52] == '0) ? 12'd1 : {1'b0, divisor_bits[62:52]};
			special_q <= 1'b0;
			done_q <= 1'b0;
		end else if (cmd.norm) begin
			if (sp_nan) begin
				special_q <= 1'b1;
				res_q <= QnanBits;
			end else if (sp_pass) begin
				special_q <= 1'b1;
				res_q <= {sx_q, ax_q};
			end else if (!nx) begin
				mx_q <= {mx_q[SigW-2:0], 1'b0};
				ex_q <= ex_q - 1'b1;
			end else if (!np) begin
				mp_q <= {mp_q[SigW-2:0], 1'b0};
				ep_q <= ep_q - 1'b1;
			end else begin
				if ($signed(ex_q) >= $signed(ep_q)) begin
					done_q <= 1'b1;
					cnt_q <= ex_q - ep_q;
					acc_q <= ({2'b0, mx_q} >= mod2) ? {2'b0, mx_q} - mod2 : {2'b0, mx_q};
					pu_q <= {2'b0, mp_q};
					base_q <= ep_q;
				end else if (ep_q - ex_q == 12'd1) begin
					done_q <= 1'b1;
					cnt_q <= '0;
					acc_q <= {2'b0, mx_q};
					pu_q <= mod2;
					base_q <= ex_q;
				end else begin
					special_q <= 1'b1;
					res_q <= {sx_q, ax_q};
				end
			end
		end else if (cmd.step) begin
			if (cnt_q != '0) begin
				acc_q <= (acc2 >= mod2) ? acc2 - mod2 : acc2;
				cnt_q <= cnt_q - 1'b1;
			end else begin
				r_q <= $signed({1'b0, acc_q});
			end
		end else if (cmd.fix) begin
			logic signed [SigW+2:0] r1;
			r1 = r_q;
			if ((r_q <<< 1) > pu_s) begin
				r1 = r_m;
				if ((r1 <<< 1) >= pu_s) r1 = r1 - pu_s;
			end
			if (r1 < 0) begin
				mag_q <= SigW'(0) + (SigW+2)'(-r1);
				sign_q <= ~sx_q;
			end else begin
				mag_q <= (SigW+2)'(r1);
				sign_q <= sx_q;
			end
		end else if (cmd.pack) begin
			if (mag_q == '0) begin
				res_q <= {sign_q, 63'd0};
			end else if (mag_q[SigW+1:SigW] != 2'b00 || base_low) begin
				mag_q <= mag_q >> 1;
				base_q <= base_q + 1'b1;
			end else if (mag_q[SigW-1]) begin
				res_q <= {sign_q, base_q[10:0], mag_q[SigW-2:0]};
			end else if (base_q == 12'd1) begin
				res_q <= {sign_q, 11'd0, mag_q[SigW-2:0]};
			end else begin
				mag_q <= mag_q << 1;
				base_q <= base_q - 1'b1;
			end
		end
	end

endmodule

[sv/dir_checker.sv]
module dir_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("input ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction taken while busy");

endmodule

bind double_ieee_remainder dir_checker u_chk (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps

class rem_scoreboard;
	logic [63:0] pending[$];
	int errors;
	int checked;

	function logic [63:0] ieee_rem(logic [63:0] x, logic [63:0] p);
		logic [63:0] sx, ax, ap, mx, mp, acc, mod2, mag, sign;
		int ex, ep, base, k, biased;
		longint r, pu;
		sx = x & 64'h8000_0000_0000_0000;
		ax = x & 64'h7FFF_FFFF_FFFF_FFFF;
		ap = p & 64'h7FFF_FFFF_FFFF_FFFF;
		if (ap == 0 || ax >= dir_pkg::ExpMask || ap > dir_pkg::ExpMask)
			return dir_pkg::QnanBits;
		if (ap == dir_pkg::ExpMask || ax == 0)
			return x;
		mx = ax & 64'h000F_FFFF_FFFF_FFFF;
		if (ax[62:52] == 0) begin
			ex = -1074;
			while (mx < 64'h0010_0000_0000_0000) begin
				mx = mx << 1;
				ex--;
			end
		end else begin
			mx = mx | 64'h0010_0000_0000_0000;
			ex = int'(ax[62:52]) - 1075;
		end
		mp = ap & 64'h000F_FFFF_FFFF_FFFF;
		if (ap[62:52] == 0) begin
			ep = -1074;
			while (mp < 64'h0010_0000_0000_0000) begin
				mp = mp << 1;
				ep--;
			end
		end else begin
			mp = mp | 64'h0010_0000_0000_0000;
			ep = int'(ap[62:52]) - 1075;
		end
		if (ex >= ep) begin
			mod2 = mp << 1;
			acc = mx % mod2;
			for (k = 0; k < ex - ep; k++)
				acc = (acc << 1) % mod2;
			r = longint'(acc);
			pu = longint'(mp);
			base = ep;
		end else if (ep - ex == 1) begin
			r = longint'(mx);
			pu = longint'(mp << 1);
			base = ex;
		end else begin
			return x;
		end
		if (2 * r > pu) begin
			r -= pu;
			if (2 * r >= pu)
				r -= pu;
		end
		sign = sx;
		if (r < 0) begin
			mag = 64'(-r);
			sign = sign ^ 64'h8000_0000_0000_0000;
		end else begin
			mag = 64'(r);
		end
		if (mag == 0)
			return sx;
		while (mag >= 64'h0020_0000_0000_0000) begin
			mag = mag >> 1;
			base++;
		end
		while (mag < 64'h0010_0000_0000_0000) begin
			mag = mag << 1;
			base--;
		end
		biased = base + 1075;
		if (biased >= 2047)
			return sign | dir_pkg::ExpMask;
		if (biased >= 1)
			return sign | (64'(biased) << 52) | (mag & 64'h000F_FFFF_FFFF_FFFF);
		if (1 - biased >= 64)
			return sign;
		return sign | (mag >> (1 - biased));
	endfunction

	function void note_operands(logic [63:0] x, logic [63:0] p);
		pending.push_back(ieee_rem(x, p));
	endfunction

	function void check_remainder(logic [63:0] got);
		logic [63:0] want;
		checked++;
		if (pending.size() == 0) begin
			$error("remainder_bits: no transaction expected, actual %h", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (want !== got) begin
			$error("remainder_bits: expected %h, actual %h", want, got);
			errors++;
		end
	endfunction
endclass

module testbench;
	import dir_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;

	int send_idle_pct;
	int recv_idle_pct;
	int sent;
	int nspecial;
	rem_scoreboard board;

	double_ieee_remainder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_remainder(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [63:0] rand_bits64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_double(logic [63:0] near);
		logic [63:0] v;
		v = rand_bits64();
		case ($urandom_range(9))
			0: v[62:52] = 11'h000;
			1: v[62:52] = 11'h7FF;
			2: v[62:52] = near[62:52] + 11'($urandom_range(60)) - 11'd30;
			3: v[62:52] = near[62:52] + 11'($urandom_range(2)) - 11'd1;
			4: v[51:0] = 52'($urandom_range(3));
			default: v[62:52] = near[62:52] + 11'($urandom_range(200)) - 11'd100;
		endcase
		return v;
	endfunction

	task automatic send_pair(logic [63:0] x, logic [63:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {p, x};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_operands(x, p);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [63:0] dir_x[$];
		logic [63:0] dir_p[$];
		logic [63:0] x, p;
		arst_n <= 1'b0;
		board = new();
		send_idle_pct = 33;
		recv_idle_pct = 53;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_x = '{64'h4014_0000_0000_0000, 64'h401C_0000_0000_0000, 64'hC014_0000_0000_0000,
			64'h4008_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000,
			64'h7FF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'h4000_0000_0000_0000,
			64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
			64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF,
			64'hC008_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h3FE0_0000_0000_0000, 64'h0010_0000_0000_0000};
		dir_p = '{64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000,
			64'hC008_0000_0000_0000, 64'h4000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
			64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0000,
			64'h8000_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h0000_0000_0000_0001,
			64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0003, 64'h7FE0_0000_0000_0000,
			64'h4000_0000_0000_0000, 64'h4010_0000_0000_0000, 64'h0000_0000_0000_0000,
			64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0003};
		foreach (dir_x[i]) begin
			send_pair(dir_x[i], dir_p[i]);
			if (dir_x[i] == 64'h0000_0000_0000_0000)
				send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FF4_0000_0000_0000);
		end
		drain();

		for (int i = 0; i < 280; i++) begin
			if (i == 95) begin
				send_idle_pct = 53;
				recv_idle_pct = 33;
			end
			if (i == 190) begin
				drain();
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			p = rand_bits64();
			if ($urandom_range(9) < 7)
				p[62:52] = 11'($urandom_range(2045)) + 11'd1;
			x = rand_double(p);
			if (x[62:52] == 11'h7FF || p[62:52] == 11'h7FF || p[62:52] == 11'h000)
				nspecial++;
			send_pair(x, p);
		end
		drain();
		repeat (3000) @(posedge clk);
		$display("Covered %0d operand pairs (%0d with special exponent fields),",
			sent, nspecial);
		$display("%0d results checked under three handshake idling profiles.", board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#60000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

[files.f]
sv/dir_pkg.sv
sv/dir_ctrl.sv
sv/dir_dp.sv
sv/double_ieee_remainder.sv
sv/dir_checker.sv
tb/testbench.sv
